>>> hdl/dfr_pkg.sv
// Shared types, constants and the byte-wide CRC update for the packet deframer.
// No dependencies.
package dfr_pkg;

  localparam logic [7:0]  HdrFirst   = 8'hAA;
  localparam logic [7:0]  HdrSecond  = 8'h55;
  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam int unsigned NumWords   = 6;
  localparam int unsigned NumCells   = 4 * NumWords;

  // frame positions
  localparam logic [4:0] PosHunt     = 5'd0;
  localparam logic [4:0] PosHdr2     = 5'd1;
  localparam logic [4:0] PosPayFirst = 5'd2;
  localparam logic [4:0] PosPayLast  = 5'd25;
  localparam logic [4:0] PosCrcLo    = 5'd26;
  localparam logic [4:0] PosCrcHi    = 5'd27;

  typedef struct packed {
    logic clr;   // back to the initial value
    logic fold;  // fold the current byte in
  } dfr_crc_ctl_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/dfr_if.sv
// Valid/ready channel interfaces for the deframer input bytes and frame results.
// No dependencies.
interface dfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
  modport mon    (input valid, input rx_byte, input ready);
endinterface

interface dfr_out_if;
  logic        valid;
  logic        ready;
  logic        crc_ok;
  logic [31:0] word0;
  logic [31:0] word1;
  logic [31:0] word2;
  logic [31:0] word3;
  logic [31:0] word4;
  logic [31:0] word5;

  modport source (output valid, output crc_ok, output word0, output word1, output word2,
                  output word3, output word4, output word5, input ready);
  modport sink   (input valid, input crc_ok, input word0, input word1, input word2,
                  input word3, input word4, input word5, output ready);
  modport mon    (input valid, input crc_ok, input word0, input word1, input word2,
                  input word3, input word4, input word5, input ready);
endinterface

>>> hdl/dfr_cell.sv
// One byte cell of the payload shift line; takes its neighbor's byte on shift.
// No dependencies.
module dfr_cell (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] data_i,
  output logic [7:0] data_o
);

  logic [7:0] data_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

>>> hdl/dfr_crc.sv
// Running CRC register, updated one byte per fold.
// Depends on dfr_pkg.
module dfr_crc
  import dfr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  dfr_crc_ctl_t ctl_i,
  input  logic [7:0]   data_i,
  output logic [15:0]  crc_o
);

  logic [15:0] crc_q, crc_d;

  always_comb begin
    crc_d = crc_q;
    if (ctl_i.clr) begin
      crc_d = CrcInit;
    end else if (ctl_i.fold) begin
      crc_d = crc_fold(crc_q, data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcInit;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

>>> hdl/sync_crc16_packet_deframer.sv
// Latency: a frame result is valid the cycle after its last CRC byte is accepted.
// Throughput: one byte per cycle, one result per 28-byte frame; the byte cells take
// payload bytes and the CRC register header and payload bytes, and input only waits
// when a frame's last CRC byte meets a result that the sink has not yet taken.
// Reset: hunting for the header, CRC at 0xFFFF, no result pending.
// Depends on dfr_pkg, dfr_if, dfr_cell, dfr_crc.
module sync_crc16_packet_deframer
  import dfr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  dfr_in_if.sink    rx_i,
  dfr_out_if.source res_o
);

  logic [4:0]   pos_q, pos_d;
  logic [7:0]   crc_lo_q;
  logic [15:0]  crc;
  logic         rx_take;
  logic         shift;
  logic         emit;
  dfr_crc_ctl_t crc_ctl;
  logic [7:0]   cell_q [NumCells];

  logic         out_valid_q;
  logic         out_ok_q;
  logic [31:0]  out_word_q [NumWords];

  // only the byte that completes a frame needs room in the output register
  assign rx_i.ready = !out_valid_q || res_o.ready || (pos_q != PosCrcHi);
  assign rx_take    = rx_i.valid && rx_i.ready;

  always_comb begin
    pos_d       = pos_q;
    shift       = 1'b0;
    emit        = 1'b0;
    crc_ctl     = '0;
    if (rx_take) begin
      if (pos_q == PosHunt) begin
        if (rx_i.rx_byte == HdrFirst) begin
          crc_ctl.fold = 1'b1;
          pos_d        = PosHdr2;
        end
      end else if (pos_q == PosHdr2) begin
        if (rx_i.rx_byte == HdrSecond) begin
          crc_ctl.fold = 1'b1;
          pos_d        = PosPayFirst;
        end else begin
          crc_ctl.clr  = 1'b1;
          pos_d        = PosHunt;
        end
      end else if (pos_q <= PosPayLast) begin
        shift        = 1'b1;
        crc_ctl.fold = 1'b1;
        pos_d        = pos_q + 5'd1;
      end else if (pos_q == PosCrcLo) begin
        pos_d        = PosCrcHi;
      end else begin
        // last CRC byte, or an out-of-range position
        emit         = (pos_q == PosCrcHi);
        crc_ctl.clr  = 1'b1;
        pos_d        = PosHunt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PosHunt;
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_take && pos_q == PosCrcLo) begin
      crc_lo_q <= rx_i.rx_byte;
    end
    if (emit) begin
      out_ok_q <= ({rx_i.rx_byte, crc_lo_q} == crc);
      for (int w = 0; w < NumWords; w++) begin
        out_word_q[w] <= {cell_q[4*w+3], cell_q[4*w+2], cell_q[4*w+1], cell_q[4*w]};
      end
    end
  end

  dfr_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (crc_ctl),
    .data_i (rx_i.rx_byte),
    .crc_o  (crc)
  );

  // bytes enter at the top cell and move down; cell 0 ends up with frame byte 2
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    logic [7:0] cell_in;
    if (i == NumCells - 1) begin : g_top
      assign cell_in = rx_i.rx_byte;
    end else begin : g_mid
      assign cell_in = cell_q[i+1];
    end
    dfr_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .data_i  (cell_in),
      .data_o  (cell_q[i])
    );
  end

  assign res_o.valid  = out_valid_q;
  assign res_o.crc_ok = out_ok_q;
  assign res_o.word0  = out_word_q[0];
  assign res_o.word1  = out_word_q[1];
  assign res_o.word2  = out_word_q[2];
  assign res_o.word3  = out_word_q[3];
  assign res_o.word4  = out_word_q[4];
  assign res_o.word5  = out_word_q[5];

endmodule

>>> hdl/dfr_checker.sv
// Port-level checks on the deframer channels, bound to the top level.
// Depends on the channel signals of sync_crc16_packet_deframer.
module dfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rx_valid_i,
  input logic        rx_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic        res_crc_ok_i,
  input logic [31:0] res_word0_i,
  input logic [31:0] res_word5_i
);

  // a result only appears right after an input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(rx_valid_i && rx_ready_i))
    else $error("result appeared without an input transaction");

  // with no result pending, input is always ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_i |-> rx_ready_i)
    else $error("input stalled with empty output register");

  // a drained result with no new input leaves the output empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && res_ready_i && !(rx_valid_i && rx_ready_i)) |=> !res_valid_i)
    else $error("result repeated");

  // stalled result holds: valid, CRC flag, word0 and word5 stay
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> (res_valid_i && $stable(res_crc_ok_i)
      && $stable(res_word0_i) && $stable(res_word5_i)))
    else $error("stalled result changed");

endmodule

bind sync_crc16_packet_deframer dfr_checker u_dfr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rx_valid_i   (rx_i.valid),
  .rx_ready_i   (rx_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_crc_ok_i (res_o.crc_ok),
  .res_word0_i  (res_o.word0),
  .res_word5_i  (res_o.word5)
);
